// File: rtl/usp_pkg.sv
// Shared types and codes for the UDP session peer table.
package usp_pkg;

  localparam int SES_W = 4;

  // Operation codes
  localparam logic [2:0] MODE_START     = 3'd0;
  localparam logic [2:0] MODE_END       = 3'd1;
  localparam logic [2:0] MODE_KEEPALIVE = 3'd2;
  localparam logic [2:0] MODE_PAYLOAD   = 3'd3;
  localparam logic [2:0] MODE_RETRANS   = 3'd4;
  localparam logic [2:0] MODE_SWEEP     = 3'd5;
  localparam logic [2:0] MODE_CLOSE_ALL = 3'd6;
  localparam logic [2:0] MODE_UNKNOWN   = 3'd7;

  // Event codes
  localparam logic [3:0] EV_OK          = 4'd0;
  localparam logic [3:0] EV_CONNECTED   = 4'd1;
  localparam logic [3:0] EV_ENDED       = 4'd2;
  localparam logic [3:0] EV_ACCEPTED    = 4'd3;
  localparam logic [3:0] EV_BAD_SIZE    = 4'd4;
  localparam logic [3:0] EV_BAD_STATE   = 4'd5;
  localparam logic [3:0] EV_FULL        = 4'd6;
  localparam logic [3:0] EV_UNSUPPORTED = 4'd7;
  localparam logic [3:0] EV_KEEPALIVE   = 4'd8;
  localparam logic [3:0] EV_TIMED_OUT   = 4'd9;
  localparam logic [3:0] EV_SEND_END    = 4'd10;
  localparam logic [3:0] EV_DONE        = 4'd11;

  localparam logic [10:0] MIN_PAYLOAD_LEN = 11'd5;
  localparam logic [31:0] TIMEOUT_RESET   = 32'd30000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [10:0] packet_length;
    logic [31:0] now_ms;
  } cmd_word_t;

  typedef struct packed {
    logic [3:0]       event_res;
    logic [SES_W-1:0] session_number;
    logic [31:0]      result_address;
    logic [15:0]      result_port;
    logic [31:0]      received_count;
    logic             last;
  } res_word_t;

  typedef struct packed {
    logic [31:0]      address;
    logic [15:0]      port;
    logic [SES_W-1:0] session;
    logic             connected;
    logic [31:0]      last_seen;
    logic [31:0]      packets;
  } entry_t;

endpackage

// File: rtl/udp_session_peer_table.sv
// UDP session peer table: top level with entry memory and sequencer.
//
// One command word is taken when start is high and busy is low. Results
// come out one per cycle at most on result, each marked by result_strobe
// for one cycle; the receiver cannot stall them, and last marks the final
// result of a command. The peer table sits in a single-port-write,
// single-read memory of MAX_PEERS entries with a synchronous read, and
// a sequencer walks it entry by entry, reading and then checking each.
// Retransmit, unknown mode and bad-size commands are answered straight
// from idle without a table walk; a lookup reads entries in order until
// a hit or the end of the table; removing an entry shifts the later
// entries down by one; a sweep or close-all visits every peer, plus the
// shifts of removed peers. timeout_we writes the session timeout.
module udp_session_peer_table #(
  parameter int MAX_PEERS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  usp_pkg::cmd_word_t cmd,
  output logic               busy,
  output logic               result_strobe,
  output usp_pkg::res_word_t result,
  input  logic               timeout_we,
  input  logic [31:0]        timeout_wdata
);
  import usp_pkg::*;

  localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CW = $clog2(MAX_PEERS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PEERS);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND_RD, S_FIND_CHK, S_SHIFT_RD, S_SHIFT_WR,
    S_SWEEP_RD, S_SWEEP_CHK, S_CLOSE_RD, S_CLOSE_CHK
  } state_t;

  state_t      state;
  cmd_word_t   op;
  logic [31:0] timeout;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] sp;
  logic        ret_sweep;

  entry_t      mem [MAX_PEERS];
  entry_t      mem_q;
  logic [IW-1:0] raddr;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  entry_t      wr_data;

  logic        hit;
  logic        expired;
  logic [CW-1:0] sp_inc;

  function automatic res_word_t mk(logic [3:0] ev, logic [SES_W-1:0] ses,
                                   logic [31:0] a, logic [15:0] p,
                                   logic [31:0] c, logic l);
    res_word_t r;
    r.event_res      = ev;
    r.session_number = ses;
    r.result_address = a;
    r.result_port    = p;
    r.received_count = c;
    r.last           = l;
    return r;
  endfunction

  // Entry memory: registered write request, synchronous read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[raddr];
  end

  assign sp_inc = sp + CW'(1);

  always_comb begin
    if (state == S_SHIFT_RD) begin
      raddr = sp_inc[IW-1:0];
    end else begin
      raddr = idx[IW-1:0];
    end
  end

  assign hit     = (mem_q.address == op.peer_address) && (mem_q.port == op.peer_port);
  assign expired = (op.now_ms - mem_q.last_seen) > timeout;
  assign busy    = (state != S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      timeout       <= TIMEOUT_RESET;
      result_strobe <= 1'b0;
      wr_en         <= 1'b0;
      idx           <= '0;
      sp            <= '0;
      ret_sweep     <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      wr_en         <= 1'b0;
      if (timeout_we) begin
        timeout <= timeout_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op  <= cmd;
            idx <= '0;
            if (cmd.mode <= MODE_RETRANS && cmd.packet_length == '0) begin
              result_strobe <= 1'b1;
              result <= mk(EV_BAD_SIZE, '0, cmd.peer_address, cmd.peer_port, '0, 1'b1);
            end else if (cmd.mode == MODE_PAYLOAD &&
                         cmd.packet_length < MIN_PAYLOAD_LEN) begin
              result_strobe <= 1'b1;
              result <= mk(EV_BAD_SIZE, '0, cmd.peer_address, cmd.peer_port, '0, 1'b1);
            end else if (cmd.mode == MODE_RETRANS) begin
              result_strobe <= 1'b1;
              result <= mk(EV_OK, '0, cmd.peer_address, cmd.peer_port, '0, 1'b1);
            end else if (cmd.mode == MODE_SWEEP) begin
              state <= S_SWEEP_RD;
            end else if (cmd.mode == MODE_CLOSE_ALL) begin
              state <= S_CLOSE_RD;
            end else if (cmd.mode <= MODE_PAYLOAD) begin
              state <= S_FIND_RD;
            end else begin
              result_strobe <= 1'b1;
              result <= mk(EV_UNSUPPORTED, '0, cmd.peer_address, cmd.peer_port, '0,
                           1'b1);
            end
          end
        end

        // Issue a lookup read, or handle a miss at the end of the table
        S_FIND_RD: begin
          if (idx < count) begin
            state <= S_FIND_CHK;
          end else begin
            state         <= S_IDLE;
            result_strobe <= 1'b1;
            if (op.mode == MODE_START) begin
              if (count >= MAX_CNT) begin
                result <= mk(EV_FULL, '0, op.peer_address, op.peer_port, '0, 1'b1);
              end else begin
                wr_en   <= 1'b1;
                wr_addr <= count[IW-1:0];
                wr_data <= '{address: op.peer_address, port: op.peer_port,
                             session: SES_W'(count + CW'(1)), connected: 1'b1,
                             last_seen: op.now_ms, packets: '0};
                count   <= count + CW'(1);
                result <= mk(EV_CONNECTED, SES_W'(count + CW'(1)), op.peer_address,
                             op.peer_port, '0, 1'b1);
              end
            end else if (op.mode == MODE_PAYLOAD) begin
              result <= mk(EV_BAD_STATE, '0, op.peer_address, op.peer_port, '0, 1'b1);
            end else begin
              result <= mk(EV_OK, '0, op.peer_address, op.peer_port, '0, 1'b1);
            end
          end
        end

        // Compare one entry and act on a hit
        S_FIND_CHK: begin
          if (!hit) begin
            idx   <= idx + CW'(1);
            state <= S_FIND_RD;
          end else begin
            state         <= S_IDLE;
            result_strobe <= 1'b1;
            wr_addr       <= idx[IW-1:0];
            priority case (op.mode)
              MODE_START: begin
                wr_en   <= 1'b1;
                wr_data <= '{address: mem_q.address, port: mem_q.port,
                             session: mem_q.session, connected: 1'b1,
                             last_seen: op.now_ms, packets: mem_q.packets};
                result <= mk(EV_CONNECTED, mem_q.session, mem_q.address, mem_q.port,
                             mem_q.packets, 1'b1);
              end
              MODE_END: begin
                result <= mk(EV_ENDED, mem_q.session, mem_q.address, mem_q.port,
                             mem_q.packets, 1'b1);
                sp        <= idx;
                ret_sweep <= 1'b0;
                state     <= S_SHIFT_RD;
              end
              MODE_KEEPALIVE: begin
                wr_en   <= 1'b1;
                wr_data <= '{address: mem_q.address, port: mem_q.port,
                             session: mem_q.session, connected: mem_q.connected,
                             last_seen: op.now_ms, packets: mem_q.packets};
                result <= mk(EV_OK, mem_q.session, mem_q.address, mem_q.port,
                             mem_q.packets, 1'b1);
              end
              default: begin
                if (!mem_q.connected) begin
                  result <= mk(EV_BAD_STATE, '0, op.peer_address, op.peer_port, '0,
                               1'b1);
                end else begin
                  wr_en   <= 1'b1;
                  wr_data <= '{address: mem_q.address, port: mem_q.port,
                               session: mem_q.session, connected: mem_q.connected,
                               last_seen: op.now_ms,
                               packets: mem_q.packets + 32'd1};
                  result <= mk(EV_ACCEPTED, mem_q.session, mem_q.address, mem_q.port,
                               mem_q.packets + 32'd1, 1'b1);
                end
              end
            endcase
          end
        end

        // Shift later entries down by one over the removed slot
        S_SHIFT_RD: begin
          if (sp_inc < count) begin
            state <= S_SHIFT_WR;
          end else begin
            count <= count - CW'(1);
            state <= ret_sweep ? S_SWEEP_RD : S_IDLE;
          end
        end

        S_SHIFT_WR: begin
          wr_en   <= 1'b1;
          wr_addr <= sp[IW-1:0];
          wr_data <= mem_q;
          sp      <= sp_inc;
          state   <= S_SHIFT_RD;
        end

        // Sweep: drop expired peers, ask keepalive of the rest
        S_SWEEP_RD: begin
          if (idx < count) begin
            state <= S_SWEEP_CHK;
          end else begin
            state         <= S_IDLE;
            result_strobe <= 1'b1;
            result        <= mk(EV_DONE, '0, '0, '0, '0, 1'b1);
          end
        end

        S_SWEEP_CHK: begin
          if (!mem_q.connected) begin
            idx   <= idx + CW'(1);
            state <= S_SWEEP_RD;
          end else if (expired) begin
            result_strobe <= 1'b1;
            result <= mk(EV_TIMED_OUT, mem_q.session, mem_q.address, mem_q.port,
                         mem_q.packets, 1'b0);
            sp        <= idx;
            ret_sweep <= 1'b1;
            state     <= S_SHIFT_RD;
          end else begin
            result_strobe <= 1'b1;
            result <= mk(EV_KEEPALIVE, mem_q.session, mem_q.address, mem_q.port,
                         mem_q.packets, 1'b0);
            idx   <= idx + CW'(1);
            state <= S_SWEEP_RD;
          end
        end

        // Close-all: send end to every peer, then empty the table
        S_CLOSE_RD: begin
          if (idx < count) begin
            state <= S_CLOSE_CHK;
          end else begin
            count         <= '0;
            state         <= S_IDLE;
            result_strobe <= 1'b1;
            result        <= mk(EV_DONE, '0, '0, '0, '0, 1'b1);
          end
        end

        S_CLOSE_CHK: begin
          result_strobe <= 1'b1;
          result <= mk(EV_SEND_END, mem_q.session, mem_q.address, mem_q.port,
                       mem_q.packets, 1'b0);
          idx   <= idx + CW'(1);
          state <= S_CLOSE_RD;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/usp_checker.sv
// Port-level checks for the UDP session peer table, bound to the top level.
module usp_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               result_strobe,
  input usp_pkg::res_word_t result
);
  import usp_pkg::*;

  // An accepted word either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> result_strobe || busy)
    else $error("accepted word neither answered nor in progress");

  // Only sweep and close-all give results that are not final
  a_nonfinal_kind: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.last |->
      (result.event_res == EV_KEEPALIVE || result.event_res == EV_TIMED_OUT ||
       result.event_res == EV_SEND_END))
    else $error("non-final result of an unexpected kind");

  // More results follow while not last
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.last |-> busy)
    else $error("non-final result with block idle");

  // Done closes a sweep or close-all
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.event_res == EV_DONE |-> result.last)
    else $error("done result not marked last");

endmodule

bind udp_session_peer_table usp_checker u_usp_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .result_strobe(result_strobe), .result(result)
);
